// ===== rtl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  // Parser phases, one per kind of byte expected next.
  typedef enum logic [2:0] {
    PH_HEAD0   = 3'd0,
    PH_HEAD1   = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  // Result event codes.
  typedef enum logic [1:0] {
    EV_DATA      = 2'd0,
    EV_EMPTY     = 2'd1,
    EV_LONG_LEN  = 2'd2,
    EV_TOO_LARGE = 2'd3
  } event_kind_t;

  localparam int unsigned CFG_W = 17;

  // Length tag codes of the second header byte.
  localparam logic [6:0] TAG_MAX_SHORT = 7'd125;
  localparam logic [6:0] TAG_EXT16     = 7'd126;
  localparam logic [6:0] TAG_EXT64     = 7'd127;

  // Header byte counts used for the whole-frame size.
  localparam logic [CFG_W-1:0] BASE_HEADER_BYTES = 17'd2;
  localparam logic [CFG_W-1:0] EXT_LEN_BYTES     = 17'd2;
  localparam logic [CFG_W-1:0] KEY_BYTES         = 17'd4;

  localparam logic [CFG_W-1:0] MAX_FRAME_RESET = 17'd65543;

  // One result produced by the parser for an accepted byte.
  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    event_kind_t kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        last;
  } wsd_result_t;

endpackage

// ===== rtl/wsd_parser.sv =====
// Frame header parser and payload unmasking for the WebSocket frame deframer.
module wsd_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               in_byte,
  input  logic [wsd_pkg::CFG_W-1:0] max_frame_bytes,
  output wsd_pkg::wsd_result_t     result
);
  import wsd_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  head_byte;
  logic        mask_on;
  logic [15:0] payload_length;
  logic [31:0] mask_key;
  logic [1:0]  header_count;
  logic [15:0] payload_left;
  logic [1:0]  key_index;
  logic        halted;

  logic [6:0]       tag;
  logic             tag_short;
  logic             len_known;
  logic             mask_now;
  logic [15:0]      len_now;
  logic [CFG_W-1:0] total;
  logic             too_large;
  logic             long_len;
  logic             key_done;
  logic             empty_frame;
  logic             start_now;
  logic             start_key;
  logic             last_payload;
  logic [7:0]       key_byte;
  logic             active;

  // Shared decode of the current byte against the parser state.
  assign active       = step && !halted;
  assign tag          = in_byte[6:0];
  assign tag_short    = (tag <= TAG_MAX_SHORT);
  assign len_known    = ((phase == PH_HEAD1) && tag_short) || (phase == PH_LEN_LO);
  assign mask_now     = (phase == PH_HEAD1) ? in_byte[7] : mask_on;
  assign len_now      = (phase == PH_LEN_LO) ? {payload_length[15:8], in_byte}
                                             : {9'd0, tag};
  assign total        = {1'b0, len_now} + BASE_HEADER_BYTES
                      + ((phase == PH_LEN_LO) ? EXT_LEN_BYTES : '0)
                      + (mask_now ? KEY_BYTES : '0);
  assign too_large    = len_known && (total > max_frame_bytes);
  assign long_len     = (phase == PH_HEAD1) && (tag == TAG_EXT64);
  assign key_done     = (phase == PH_KEY) && (header_count == 2'd3);
  assign start_now    = len_known && !too_large && !mask_now;
  assign start_key    = len_known && !too_large && mask_now;
  assign empty_frame  = (start_now && (len_now == 16'd0))
                     || (key_done && (payload_length == 16'd0));
  assign last_payload = (payload_left == 16'd1);

  // Key byte for the current payload position; unmasked frames use zero.
  always_comb begin
    case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
    if (!mask_on) begin
      key_byte = 8'd0;
    end
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEAD0: begin
        phase_next = PH_HEAD1;
      end
      PH_HEAD1: begin
        if (tag == TAG_EXT16) begin
          phase_next = PH_LEN_HI;
        end else if (start_key) begin
          phase_next = PH_KEY;
        end else if (start_now) begin
          phase_next = empty_frame ? PH_HEAD0 : PH_PAYLOAD;
        end
      end
      PH_LEN_HI: begin
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (start_key) begin
          phase_next = PH_KEY;
        end else if (start_now) begin
          phase_next = empty_frame ? PH_HEAD0 : PH_PAYLOAD;
        end
      end
      PH_KEY: begin
        if (key_done) begin
          phase_next = empty_frame ? PH_HEAD0 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (last_payload) begin
          phase_next = PH_HEAD0;
        end
      end
      default: begin
        phase_next = PH_HEAD0;
      end
    endcase
  end

  // Result for the current byte.
  always_comb begin
    result.valid  = active && ((phase == PH_PAYLOAD) || empty_frame || too_large || long_len);
    result.data   = (phase == PH_PAYLOAD) ? (in_byte ^ key_byte) : 8'd0;
    result.fin    = head_byte[7];
    result.opcode = head_byte[3:0];
    result.last   = (phase == PH_PAYLOAD) ? last_payload : 1'b1;
    if (long_len) begin
      result.kind = EV_LONG_LEN;
    end else if (too_large) begin
      result.kind = EV_TOO_LARGE;
    end else if (phase == PH_PAYLOAD) begin
      result.kind = EV_DATA;
    end else begin
      result.kind = EV_EMPTY;
    end
  end

  // Parser state registers; an error halts the parser until reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEAD0;
      head_byte      <= 8'd0;
      mask_on        <= 1'b0;
      payload_length <= 16'd0;
      mask_key       <= 32'd0;
      header_count   <= 2'd0;
      payload_left   <= 16'd0;
      key_index      <= 2'd0;
      halted         <= 1'b0;
    end else if (active) begin
      phase <= phase_next;
      if (too_large || long_len) begin
        halted <= 1'b1;
      end
      if (phase == PH_HEAD0) begin
        head_byte <= in_byte;
      end
      if (phase == PH_HEAD1) begin
        mask_on        <= in_byte[7];
        payload_length <= tag_short ? {9'd0, tag} : 16'd0;
      end
      if (phase == PH_LEN_HI) begin
        payload_length <= {in_byte, 8'd0};
      end
      if (phase == PH_LEN_LO) begin
        payload_length <= len_now;
      end
      if (start_key) begin
        header_count <= 2'd0;
        mask_key     <= 32'd0;
      end
      if (phase == PH_KEY) begin
        mask_key     <= {mask_key[23:0], in_byte};
        header_count <= header_count + 2'd1;
      end
      if (start_now) begin
        payload_left <= len_now;
        key_index    <= 2'd0;
      end else if (key_done) begin
        payload_left <= payload_length;
        key_index    <= 2'd0;
      end else if (phase == PH_PAYLOAD) begin
        payload_left <= payload_left - 16'd1;
        key_index    <= key_index + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/websocket_frame_deframer_top.sv =====
// Top level of the WebSocket frame deframer: handshakes, size register and result register.
//
// The deframer takes one stream byte per cycle and gives each result in the cycle after
// the byte that causes it, through a single result register. A byte request is taken
// whenever that register is empty or being drained in the same cycle, so with out_ready
// held high the block sustains one byte per clock; a stalled output holds off input.
// Header, extended length and key bytes give no result unless they finish an empty frame
// or raise an error. After a 64-bit length tag or an oversized frame the block reports
// the error once and then discards all input until reset. max_frame_bytes may be written
// in any cycle and applies to frames whose length is learned afterward.
module websocket_frame_deframer_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [wsd_pkg::CFG_W-1:0] max_frame_bytes,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic [1:0]                event_kind,
  output logic                      fin_flag,
  output logic [3:0]                opcode,
  output logic                      last_in_frame
);
  import wsd_pkg::*;

  logic [CFG_W-1:0] max_bytes;
  logic             in_fire;
  wsd_result_t      result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Frame size limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_bytes <= max_frame_bytes;
    end
  end

  wsd_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .step            (in_fire),
    .in_byte         (in_byte),
    .max_frame_bytes (max_bytes),
    .result          (result)
  );

  // Result register; valid control is reset, the payload is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && result.valid) begin
      out_byte      <= result.data;
      event_kind    <= result.kind;
      fin_flag      <= result.fin;
      opcode        <= result.opcode;
      last_in_frame <= result.last;
    end
  end

endmodule

// ===== rtl/wsd_checker.sv =====
// Port-level assertions for the WebSocket frame deframer, bound to the top level.
module wsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] event_kind,
  input logic       fin_flag,
  input logic [3:0] opcode,
  input logic       last_in_frame
);
  import wsd_pkg::*;

  // A stalled result request keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(event_kind)
      && $stable(fin_flag) && $stable(opcode) && $stable(last_in_frame))
    else $error("result changed while stalled");

  // Events other than payload bytes carry a zero byte and close the frame.
  a_event_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind != EV_DATA) |-> (out_byte == 8'd0) && last_in_frame)
    else $error("non-payload event with data or open frame");

  // Once an error is taken, the result register is left empty.
  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (event_kind == EV_LONG_LEN || event_kind == EV_TOO_LARGE)
      |=> !out_valid)
    else $error("result after an error");

  // An empty result register always takes input.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (.*);

// ===== tb/tb_websocket_frame_deframer_top.sv =====
// Self-checking testbench for the WebSocket frame deframer top level.
module tb_websocket_frame_deframer_top;
  import wsd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  // Tracks the parser state alongside the block and holds the events it still owes.
  class deframer_scoreboard;
    phase_t             parse_phase;
    logic [7:0]         head_byte;
    logic               mask_on;
    logic               ext_present;
    logic [15:0]        frame_len;
    logic [31:0]        mask_key;
    logic [1:0]         key_count;
    logic [15:0]        bytes_left;
    logic [1:0]         key_pos;
    logic               halted;
    logic [CFG_W-1:0]   limit_bytes;
    wsd_result_t        due_events[$];
    int                 mismatches;
    int                 bytes_seen;
    int                 results_checked;

    function new();
      parse_phase = PH_HEAD0;
      head_byte = '0;
      mask_on = 1'b0;
      ext_present = 1'b0;
      frame_len = '0;
      mask_key = '0;
      key_count = '0;
      bytes_left = '0;
      key_pos = '0;
      halted = 1'b0;
      limit_bytes = MAX_FRAME_RESET;
      mismatches = 0;
      bytes_seen = 0;
      results_checked = 0;
    endfunction

    function int outstanding();
      return due_events.size();
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      limit_bytes = v;
    endfunction

    // Queue one event tagged with the current frame's header fields.
    function void owe_event(logic [7:0] data, event_kind_t kind, logic last);
      wsd_result_t ev;
      ev.valid = 1'b1;
      ev.data = data;
      ev.kind = kind;
      ev.fin = head_byte[7];
      ev.opcode = head_byte[3:0];
      ev.last = last;
      due_events.push_back(ev);
    endfunction

    // Enter the payload, or close out a frame that carries none.
    function void open_payload();
      if (frame_len == 16'd0) begin
        parse_phase = PH_HEAD0;
        owe_event(8'h00, EV_EMPTY, 1'b1);
      end else begin
        bytes_left = frame_len;
        key_pos = '0;
        parse_phase = PH_PAYLOAD;
      end
    endfunction

    // The length is now known: check the whole frame size before going on.
    function void length_settled();
      logic [CFG_W-1:0] total;
      total = BASE_HEADER_BYTES + (ext_present ? EXT_LEN_BYTES : '0) +
              (mask_on ? KEY_BYTES : '0) + frame_len;
      if (total > limit_bytes) begin
        halted = 1'b1;
        owe_event(8'h00, EV_TOO_LARGE, 1'b1);
      end else if (mask_on) begin
        key_count = '0;
        mask_key = '0;
        parse_phase = PH_KEY;
      end else begin
        open_payload();
      end
    endfunction

    // Advance the parser by one accepted stream byte request.
    function void note_byte(logic [7:0] b);
      logic [6:0] tag;
      logic [7:0] key_byte;
      bytes_seen++;
      if (halted) return;
      case (parse_phase)
        PH_HEAD0: begin
          head_byte = b;
          parse_phase = PH_HEAD1;
        end
        PH_HEAD1: begin
          mask_on = b[7];
          tag = b[6:0];
          if (tag <= TAG_MAX_SHORT) begin
            ext_present = 1'b0;
            frame_len = {9'd0, tag};
            length_settled();
          end else if (tag == TAG_EXT16) begin
            ext_present = 1'b1;
            frame_len = '0;
            parse_phase = PH_LEN_HI;
          end else begin
            halted = 1'b1;
            owe_event(8'h00, EV_LONG_LEN, 1'b1);
          end
        end
        PH_LEN_HI: begin
          frame_len = {b, 8'h00};
          parse_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len[7:0] = b;
          length_settled();
        end
        PH_KEY: begin
          mask_key = {mask_key[23:0], b};
          key_count = key_count + 2'd1;
          if (key_count == 2'd0) open_payload();
        end
        PH_PAYLOAD: begin
          key_byte = mask_on ? mask_key[31 - 8 * key_pos -: 8] : 8'h00;
          key_pos = key_pos + 2'd1;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) begin
            parse_phase = PH_HEAD0;
            owe_event(b ^ key_byte, EV_DATA, 1'b1);
          end else begin
            owe_event(b ^ key_byte, EV_DATA, 1'b0);
          end
        end
        default: parse_phase = PH_HEAD0;
      endcase
    endfunction

    // Compare one accepted result with the oldest owed event.
    function void check_result(logic [7:0] data, logic [1:0] kind, logic fin,
                               logic [3:0] op, logic last);
      wsd_result_t ev;
      if (due_events.size() == 0) begin
        $error("unexpected result: out_byte %0h event_kind %0d", data, kind);
        mismatches++;
        return;
      end
      ev = due_events.pop_front();
      results_checked++;
      if (data !== ev.data) begin
        $error("out_byte: expected %0h, actual %0h", ev.data, data);
        mismatches++;
      end
      if (kind !== ev.kind) begin
        $error("event_kind: expected %0d, actual %0d", ev.kind, kind);
        mismatches++;
      end
      if (fin !== ev.fin) begin
        $error("fin_flag: expected %0b, actual %0b", ev.fin, fin);
        mismatches++;
      end
      if (op !== ev.opcode) begin
        $error("opcode: expected %0h, actual %0h", ev.opcode, op);
        mismatches++;
      end
      if (last !== ev.last) begin
        $error("last_in_frame: expected %0b, actual %0b", ev.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] max_frame_bytes = MAX_FRAME_RESET;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_byte;
  logic [1:0]       event_kind;
  logic             fin_flag;
  logic [3:0]       opcode;
  logic             last_in_frame;

  deframer_scoreboard sb;
  int               in_idle_pct = 0;
  int               out_stall_pct = 0;
  int               sent_bytes = 0;
  int               cfg_writes = 0;
  int               quiet_cycles = 0;
  int unsigned      frame_limit = MAX_FRAME_RESET;
  string            error_case = "none";

  websocket_frame_deframer_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .max_frame_bytes(max_frame_bytes),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .event_kind(event_kind),
    .fin_flag(fin_flag),
    .opcode(opcode),
    .last_in_frame(last_in_frame)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random at the current rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watch every handshake at the rising edge: results first, then new requests.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result(out_byte, event_kind, fin_flag, opcode, last_in_frame);
      if (in_valid && in_ready)
        sb.note_byte(in_byte);
      if (cfg_valid && cfg_ready)
        sb.set_limit(max_frame_bytes);
    end
  end

  // End the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idle(input int mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 85; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 85; end
      default: begin in_idle_pct = 30; out_stall_pct = 30; end
    endcase
  endtask

  // Offer one byte request, with random gaps ahead of it, and hold it until taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_bytes++;
  endtask

  // Let every owed event drain and the block settle before touching the register.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    max_frame_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    frame_limit = v;
    cfg_writes++;
  endtask

  // Send one whole frame with a random payload.
  task automatic send_frame(input logic [7:0] head, input logic masked, input logic use_ext,
                            input logic [15:0] len, input logic [31:0] key);
    int k;
    send_byte(head);
    if (use_ext) begin
      send_byte({masked, TAG_EXT16});
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      send_byte({masked, len[6:0]});
    end
    if (masked)
      for (k = 0; k < 4; k++) send_byte(key[31 - 8 * k -: 8]);
    for (k = 0; k < int'(len); k++) send_byte(8'($urandom_range(255)));
  endtask

  // Pick a frame layout and length that fit the current size limit.
  task automatic send_random_frame();
    logic        masked;
    logic        use_ext;
    int unsigned hdr;
    int unsigned room;
    int unsigned len;
    int          r;
    masked = 1'($urandom_range(1));
    use_ext = ($urandom_range(3) == 0);
    hdr = 2 + (use_ext ? 2 : 0) + (masked ? 4 : 0);
    if (hdr > frame_limit) begin
      use_ext = 1'b0;
      hdr = 2 + (masked ? 4 : 0);
    end
    if (hdr > frame_limit) begin
      masked = 1'b0;
      hdr = 2;
    end
    room = frame_limit - hdr;
    r = $urandom_range(99);
    if (r < 10) len = 0;
    else if (r < 13) len = 125;
    else if (r < 75) len = $urandom_range(8, 1);
    else if (r < 95) len = $urandom_range(140, 9);
    else len = $urandom_range(400, 141);
    if (len > room) len = room;
    // A short tag cannot carry more than 125 bytes.
    if (!use_ext && len > 125) begin
      if (hdr + 2 + len <= frame_limit) use_ext = 1'b1;
      else len = 125;
    end
    send_frame(8'($urandom_range(255)), masked, use_ext, 16'(len), $urandom);
  endtask

  // Finish with one error: either a 64-bit length tag or a frame too large for the limit.
  task automatic send_fatal_frame();
    logic [CFG_W-1:0] v;
    int unsigned      len;
    if ($urandom_range(1) == 0) begin
      error_case = "64-bit length tag";
      send_byte(8'($urandom_range(255)));
      send_byte({1'($urandom_range(1)), TAG_EXT64});
    end else begin
      error_case = "oversized frame";
      // Now and then a limit below the smallest frame, which rejects even empty ones.
      v = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(1)) : CFG_W'($urandom_range(300, 2));
      write_limit(v);
      send_byte(8'($urandom_range(255)));
      if (v < 2) begin
        send_byte({1'b0, 7'd0});
      end else if (v >= 5 && v <= 130 && $urandom_range(1) == 1) begin
        len = v - 5;
        send_byte({1'b1, 7'(len)});
      end else if (v - 1 <= 125) begin
        len = v - 1;
        send_byte({1'b0, 7'(len)});
      end else begin
        len = v - 3;
        send_byte({1'b0, TAG_EXT16});
        send_byte(8'(len >> 8));
        send_byte(8'(len));
      end
    end
    // Everything after the error is swallowed.
    repeat (40) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    int               p;
    int               phase_start;
    logic [CFG_W-1:0] plan[8];
    sb = new();
    plan = '{MAX_FRAME_RESET, BASE_HEADER_BYTES, CFG_W'($urandom_range(65543, 2)), 17'd7,
             17'd133, CFG_W'($urandom_range(600, 2)), MAX_FRAME_RESET, 17'd8};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    set_idle(0);

    // Directed frames under the reset limit.
    send_frame(8'h80, 1'b0, 1'b0, 16'd0, 32'h0);
    send_frame(8'h81, 1'b1, 1'b0, 16'd1, 32'hffff_ffff);
    send_frame(8'h0f, 1'b0, 1'b0, 16'd3, 32'h0);
    send_frame(8'h88, 1'b0, 1'b1, 16'd0, 32'h0);
    send_frame(8'h7a, 1'b1, 1'b1, 16'd2, 32'h00a5_5aff);

    // Random frames through a series of size limits and idle patterns.
    for (p = 0; p < 8; p++) begin
      write_limit(plan[p]);
      set_idle(p % 4);
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < 170) send_random_frame();
    end

    // One masked frame with an extended length that fills the limit exactly.
    write_limit(17'd138);
    set_idle(0);
    send_frame(8'h82, 1'b1, 1'b1, 16'd130, $urandom);

    set_idle($urandom_range(3));
    send_fatal_frame();

    settle();
    $display("Sent %0d stream bytes and checked %0d results over %0d limit settings.",
             sb.bytes_seen, sb.results_checked, cfg_writes);
    $display("The run ended on a %s error, with the bytes after it swallowed.", error_case);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
